FILE: sv/sida_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Shared widths, character codes, the queue item type and reciprocal constants.
// No dependencies.
package sida_pkg;

  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 7'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

endpackage

FILE: sv/sida_front.sv
// Front end: accepts input words, splits off the sign and forms the
// unsigned magnitude, then hands the item to the queue. Uses sida_pkg.
module sida_front
  import sida_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
  output logic               push,
  input  logic               push_ready,
  output item_t              push_item
);

  logic  f_valid;
  item_t f_item;
  logic  accept;

  assign s_tready  = !f_valid || push_ready;
  assign accept    = s_tvalid && s_tready;
  assign push      = f_valid;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.neg <= s_tdata[VALUE_W-1];
      // two's complement negate; the most negative value stays 2^31 unsigned
      f_item.mag <= s_tdata[VALUE_W-1] ? (~s_tdata + VALUE_W'(1)) : s_tdata;
    end
  end

endmodule

FILE: sv/sida_fifo.sv
// Short queue between the front and back ends.
// Holds item_t entries from sida_pkg; register file with a combinational read.
module sida_fifo
  import sida_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: sv/sida_back.sv
// Back end: splits the magnitude into decimal digits with a divide-by-ten
// unit (one digit per cycle, least significant first), then sends '-' for a
// negative value and the digits most significant first through an output register. Uses sida_pkg.
module sida_back
  import sida_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop,
  input  item_t             pop_item,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [6:0] char_code, [7] zero
  output logic              m_tlast    // last_char
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_SIGN  = 4'b0100,
    ST_DIGIT = 4'b1000
  } back_state_t;

  back_state_t        state;
  logic               neg;
  logic [VALUE_W-1:0] mag;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   rd;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [DIGIT_W-1:0]   q10_lo;
  logic [DIGIT_W-1:0]   rem;
  logic                 div_done;
  logic                 slot_free;
  logic                 emit;
  logic [CHAR_W-1:0]    emit_code;
  logic                 emit_last;
  logic [CHAR_W-1:0]    char_code;

  assign prod     = {{VALUE_W{1'b0}}, mag} * {{VALUE_W{1'b0}}, RECIP10};
  assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  // remainder needs only the low bits of mag - 10*quot
  assign q10_lo   = {quot[2:0], 1'b0} + {quot[0], 3'b000};
  assign rem      = mag[DIGIT_W-1:0] - q10_lo;
  assign div_done = (quot == '0) || (cnt == CNT_W'(MAX_DIGITS - 1));

  assign slot_free = !m_tvalid || m_tready;
  assign pop       = (state == ST_IDLE) && pop_valid;
  assign emit      = slot_free && ((state == ST_SIGN) || (state == ST_DIGIT));

  always_comb begin
    if (state == ST_SIGN) begin
      emit_code = ASCII_MINUS;
      emit_last = 1'b0;
    end else begin
      emit_code = ASCII_ZERO + CHAR_W'(digits[rd]);
      emit_last = (rd == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= neg ? ST_SIGN : ST_DIGIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            state <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (slot_free && (rd == '0)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      neg <= pop_item.neg;
      mag <= pop_item.mag;
      cnt <= '0;
    end else if (state == ST_DIV) begin
      digits[cnt[CNT_W-1:0]] <= rem;
      mag <= quot;
      cnt <= cnt + CNT_W'(1);
      if (div_done) begin
        rd <= cnt;
      end
    end else if (emit && (state == ST_DIGIT) && (rd != '0)) begin
      rd <= rd - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_code <= emit_code;
      m_tlast   <= emit_last;
    end
  end

  assign m_tdata = {1'b0, char_code};

  a_last_is_digit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE))
    else $error("last word is not a digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (char_code == ASCII_MINUS)) |-> !m_tlast)
    else $error("sign word marked last");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < CNT_W'(MAX_DIGITS)))
    else $error("digit count overrun");

  a_emit_after_div: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIV) && div_done) |=> (state == ST_SIGN) || (state == ST_DIGIT))
    else $error("divide phase did not hand over to output");

endmodule

FILE: sv/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, top level.
// Instantiates sida_front, sida_fifo and sida_back; uses sida_pkg.
//
// Each input word is a signed 32-bit integer; the output stream carries its
// decimal text one character per word: '-' for a negative value, then the
// digits most significant first with no leading zeros (zero gives "0"), with
// tlast on the final digit. For a number of n digits (1 to 10) the back end
// takes the item from the queue, forms the n digits in its divide-by-ten
// unit (one digit per cycle), then sends each character in turn, holding
// while the output is stalled. The front end and a short queue accept new
// words while the back end works, as long as there is room, so input is
// taken without waiting for output to drain.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [6:0] char_code, [7] zero
  output logic               m_tlast    // last_char
);

  logic  push;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  sida_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sida_fifo #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  sida_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
